// ===== hw/rtl/cssr_pkg.sv =====
// Shared types and constants of the sync serial report slave.
// No dependencies; every other file of the block imports this package.
package cssr_pkg;

  localparam int unsigned ReadingW   = 4;
  localparam int unsigned ButtonW    = 2;
  localparam int unsigned LedW       = 8;
  localparam int unsigned SendBits   = 2 * ReadingW + ButtonW;
  localparam int unsigned CfgIndexW  = 2;

  localparam int unsigned SyncBeatsDefault = 4;
  localparam int unsigned LedBitsDefault   = 8;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CFG_THRESH_ONE   = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_THRESH_TWO   = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_THRESH_THREE = 2'd2;

  localparam logic [ReadingW-1:0] THRESH_ONE_RST   = 4'd5;
  localparam logic [ReadingW-1:0] THRESH_TWO_RST   = 4'd8;
  localparam logic [ReadingW-1:0] THRESH_THREE_RST = 4'd11;

  // Decoded button codes: bit 1 is button one, bit 0 is button two.
  localparam logic [ButtonW-1:0] BTN_NONE = 2'b00;
  localparam logic [ButtonW-1:0] BTN_ONE  = 2'b10;
  localparam logic [ButtonW-1:0] BTN_TWO  = 2'b01;
  localparam logic [ButtonW-1:0] BTN_BOTH = 2'b11;

  localparam logic ACT_READINGS = 1'b0;
  localparam logic ACT_BEAT     = 1'b1;

  typedef struct packed {
    logic            drive_enable;
    logic            line_level;
    logic [LedW-1:0] led_level;
    logic            led_updated;
    logic            busy_res;
  } cssr_result_t;

endpackage

// ===== hw/rtl/cssr_ladder.sv =====
// Threshold registers and the button ladder decoder.
// Depends on cssr_pkg.
module cssr_ladder import cssr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [ReadingW-1:0]  cfg_data,
  input  logic [ReadingW-1:0]  reading,
  output logic [ButtonW-1:0]   buttons
);

  logic [ReadingW-1:0] thr_one_r, thr_two_r, thr_three_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_one_r   <= THRESH_ONE_RST;
      thr_two_r   <= THRESH_TWO_RST;
      thr_three_r <= THRESH_THREE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESH_ONE:   thr_one_r   <= cfg_data;
        CFG_THRESH_TWO:   thr_two_r   <= cfg_data;
        CFG_THRESH_THREE: thr_three_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // First matching test wins, even when the thresholds are out of order.
  always_comb begin
    if (reading < thr_one_r)        buttons = BTN_NONE;
    else if (reading < thr_two_r)   buttons = BTN_ONE;
    else if (reading < thr_three_r) buttons = BTN_TWO;
    else                            buttons = BTN_BOTH;
  end

endmodule

// ===== hw/rtl/cssr_link.sv =====
// Link state machine: reading cache, send and receive shifters, LED level.
// Depends on cssr_pkg. Produces the result of the item accepted this cycle.
module cssr_link import cssr_pkg::*; #(
  parameter int unsigned SYNC_BEATS = SyncBeatsDefault,
  parameter int unsigned LED_BITS   = LedBitsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                action,
  input  logic                data_in,
  input  logic [ReadingW-1:0] x_reading,
  input  logic [ReadingW-1:0] y_reading,
  input  logic [ButtonW-1:0]  buttons,
  output cssr_result_t        result
);

  localparam int unsigned MaxCount = (SYNC_BEATS > LED_BITS) ?
      ((SYNC_BEATS > SendBits) ? SYNC_BEATS : SendBits) :
      ((LED_BITS > SendBits) ? LED_BITS : SendBits);
  localparam int unsigned CntW = $clog2(MaxCount + 1);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_SYNC_OUT = 3'd1;
  localparam logic [2:0] PH_DATA_OUT = 3'd2;
  localparam logic [2:0] PH_SYNC_IN  = 3'd3;
  localparam logic [2:0] PH_DATA_IN  = 3'd4;

  logic [ReadingW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [ButtonW-1:0]  btn_r, btn_nxt;
  logic [2:0]          phase_r, phase_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic [SendBits-1:0] send_r, send_nxt;
  logic [LedW-1:0]     recv_r, recv_nxt;
  logic [LedW-1:0]     led_r, led_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= '0;
      cy_r    <= '0;
      btn_r   <= '0;
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      send_r  <= '0;
      recv_r  <= '0;
      led_r   <= '0;
    end else begin
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      btn_r   <= btn_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      send_r  <= send_nxt;
      recv_r  <= recv_nxt;
      led_r   <= led_nxt;
    end
  end

  always_comb begin
    logic [2:0]          ph;
    logic [CntW-1:0]     cnt;
    logic [CntW-1:0]     cnt_inc;
    logic [SendBits-1:0] snd;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    btn_nxt   = btn_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    send_nxt  = send_r;
    recv_nxt  = recv_r;
    led_nxt   = led_r;
    result.drive_enable = 1'b0;
    result.line_level   = 1'b0;
    result.led_updated  = 1'b0;
    ph  = phase_r;
    cnt = cnt_r;
    snd = send_r;
    cnt_inc = '0;

    if (accept) begin
      if (action == ACT_READINGS) begin
        cx_nxt  = x_reading;
        cy_nxt  = y_reading;
        btn_nxt = buttons;
      end else begin
        // A beat while idle (or in an undefined phase) starts an exchange.
        if (ph == PH_IDLE || ph > PH_DATA_IN) begin
          snd = {cx_r, cy_r, btn_r};
          cnt = '0;
          ph  = PH_SYNC_OUT;
        end
        cnt_inc = cnt + 1'b1;
        case (ph)
          PH_SYNC_OUT: begin
            result.drive_enable = 1'b1;
            if (cnt_inc >= CntW'(SYNC_BEATS)) begin
              phase_nxt = PH_DATA_OUT;
              cnt_nxt   = '0;
            end else begin
              phase_nxt = ph;
              cnt_nxt   = cnt_inc;
            end
            send_nxt = snd;
          end
          PH_DATA_OUT: begin
            result.drive_enable = 1'b1;
            result.line_level   = snd[SendBits-1];
            send_nxt = {snd[SendBits-2:0], 1'b0};
            if (cnt_inc >= CntW'(SendBits)) begin
              phase_nxt = PH_SYNC_IN;
              cnt_nxt   = '0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_SYNC_IN: begin
            if (data_in) begin
              cnt_nxt = '0;
            end else if (cnt_inc >= CntW'(SYNC_BEATS)) begin
              phase_nxt = PH_DATA_IN;
              cnt_nxt   = '0;
              recv_nxt  = '0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          default: begin
            recv_nxt = {recv_r[LedW-2:0], data_in};
            if (cnt_inc >= CntW'(LED_BITS)) begin
              led_nxt   = recv_nxt;
              result.led_updated = 1'b1;
              phase_nxt = PH_IDLE;
              cnt_nxt   = '0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
        endcase
      end
    end

    result.led_level = led_nxt;
    result.busy_res  = (phase_nxt >= PH_SYNC_OUT) && (phase_nxt <= PH_DATA_IN);
  end

endmodule

// ===== hw/rtl/clocked_sync_serial_report_slave_unit.sv =====
// Top level of the sync serial report slave: configuration port, ladder
// decoder, link state machine and a result register with a skid stage.
// Depends on cssr_pkg, cssr_ladder and cssr_link.
//
// One item is one call of the link: readings (action 0) refresh the cache,
// a beat (action 1) advances the exchange. Each item yields exactly one
// result, registered in the result register or, while that one is held, in
// the skid stage; a new item is taken every cycle unless in_stall is high.
// in_stall rises only when the result register and the skid stage both hold
// results that are not yet taken. Threshold writes are always ready and take
// effect on the next accepted item.
module clocked_sync_serial_report_slave_unit import cssr_pkg::*; #(
  parameter int unsigned SYNC_BEATS = SyncBeatsDefault,
  parameter int unsigned LED_BITS   = LedBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic                 in_data_in,
  input  logic [ReadingW-1:0]  in_x_reading,
  input  logic [ReadingW-1:0]  in_y_reading,
  input  logic [ReadingW-1:0]  in_button_reading,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_drive_enable,
  output logic                 out_line_level,
  output logic [LedW-1:0]      out_led_level,
  output logic                 out_led_updated,
  output logic                 out_busy_res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [ReadingW-1:0]  cfg_data
);

  logic         accept;
  logic [ButtonW-1:0] buttons;
  cssr_result_t res;
  cssr_result_t out_r, skid_r;
  logic         out_v_r, skid_v_r;
  logic         out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  assign accept    = in_valid && !skid_v_r;
  assign out_free  = !out_v_r || !out_stall;

  cssr_ladder u_ladder (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .reading   (in_button_reading),
    .buttons   (buttons)
  );

  cssr_link #(
    .SYNC_BEATS (SYNC_BEATS),
    .LED_BITS   (LED_BITS)
  ) u_link (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_action),
    .data_in   (in_data_in),
    .x_reading (in_x_reading),
    .y_reading (in_y_reading),
    .buttons   (buttons),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= accept;
      end
    end else if (accept) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) out_r <= skid_r;
      else if (accept) out_r <= res;
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_drive_enable = out_r.drive_enable;
  assign out_line_level   = out_r.line_level;
  assign out_led_level    = out_r.led_level;
  assign out_led_updated  = out_r.led_updated;
  assign out_busy_res     = out_r.busy_res;

endmodule

// ===== hw/rtl/cssr_checker.sv =====
// Port-level checks of the sync serial report slave, bound to the top level.
// Depends on cssr_pkg and clocked_sync_serial_report_slave_unit.
module cssr_checker import cssr_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_drive_enable,
  input logic                 out_line_level,
  input logic [LedW-1:0]      out_led_level,
  input logic                 out_led_updated,
  input logic                 out_busy_res
);

  // A result held by the receiver keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_led_level) &&
      $stable(out_busy_res) && $stable(out_line_level))
    else $error("stalled result changed");

  // No result leaves the block during or right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result present after reset");

  // The line level is always low when the line is not driven.
  a_level_driven: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_drive_enable |-> !out_line_level)
    else $error("line level set while released");

  // Completing the LED value ends the exchange on a receiving beat.
  a_led_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_led_updated |-> !out_busy_res && !out_drive_enable)
    else $error("LED update inside an exchange");

endmodule

bind clocked_sync_serial_report_slave_unit cssr_checker u_cssr_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for clocked_sync_serial_report_slave_unit.
// Depends on cssr_pkg and the block's RTL. It checks every result against
// a cycle-free model of the link exchange or the answer a typed row carries.
module tb import cssr_pkg::*; ();

  localparam int unsigned NumDirected = 31;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned PhaseItems  = 190;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC_OUT,
    PH_DATA_OUT,
    PH_SYNC_IN,
    PH_DATA_IN
  } link_phase_e;

  typedef struct packed {
    logic                act;
    logic                din;
    logic [ReadingW-1:0] x;
    logic [ReadingW-1:0] y;
    logic [ReadingW-1:0] btn;
    logic                typed;
    cssr_result_t        want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_action;
  logic                 in_data_in;
  logic [ReadingW-1:0]  in_x_reading;
  logic [ReadingW-1:0]  in_y_reading;
  logic [ReadingW-1:0]  in_button_reading;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_drive_enable;
  logic                 out_line_level;
  logic [LedW-1:0]      out_led_level;
  logic                 out_led_updated;
  logic                 out_busy_res;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [ReadingW-1:0]  cfg_data;

  // Travels with the item so the monitor knows when a row carries its own answer.
  logic                 typed_row;
  cssr_result_t         typed_want;

  clocked_sync_serial_report_slave_unit dut (.*);

  // Model state and its copy of the thresholds.
  logic [ReadingW-1:0] th_one   = THRESH_ONE_RST;
  logic [ReadingW-1:0] th_two   = THRESH_TWO_RST;
  logic [ReadingW-1:0] th_three = THRESH_THREE_RST;
  logic [ReadingW-1:0] cache_x   = '0;
  logic [ReadingW-1:0] cache_y   = '0;
  logic [ButtonW-1:0]  cache_btn = BTN_NONE;
  link_phase_e         ph        = PH_IDLE;
  logic [3:0]          beats     = '0;
  logic [SendBits-1:0] tx_bits   = '0;
  logic [LedW-1:0]     rx_bits   = '0;
  logic [LedW-1:0]     led_now   = '0;

  cssr_result_t pending_reports[$];
  int unsigned  mismatch_count = 0;
  int unsigned  items_offered = 0;
  int unsigned  quiet_cycles = 0;
  bit           sender_eager = 1'b0;
  bit           reader_eager = 1'b0;
  bit           hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic cssr_result_t link_step(input logic act, input logic din,
      input logic [ReadingW-1:0] x, input logic [ReadingW-1:0] y,
      input logic [ReadingW-1:0] btn);
    cssr_result_t r;
    r = '0;
    if (act == ACT_READINGS) begin
      cache_x = x;
      cache_y = y;
      // The first threshold that the reading falls below wins.
      if (btn < th_one) cache_btn = BTN_NONE;
      else if (btn < th_two) cache_btn = BTN_ONE;
      else if (btn < th_three) cache_btn = BTN_TWO;
      else cache_btn = BTN_BOTH;
    end else begin
      if (ph == PH_IDLE) begin
        tx_bits = {cache_x, cache_y, cache_btn};
        beats = '0;
        ph = PH_SYNC_OUT;
      end
      case (ph)
        PH_SYNC_OUT: begin
          r.drive_enable = 1'b1;
          beats = beats + 1'b1;
          if (beats >= SyncBeatsDefault) begin
            ph = PH_DATA_OUT;
            beats = '0;
          end
        end
        PH_DATA_OUT: begin
          r.drive_enable = 1'b1;
          r.line_level = tx_bits[SendBits-1];
          tx_bits = tx_bits << 1;
          beats = beats + 1'b1;
          if (beats >= SendBits) begin
            ph = PH_SYNC_IN;
            beats = '0;
          end
        end
        PH_SYNC_IN: begin
          if (din) begin
            beats = '0;
          end else begin
            beats = beats + 1'b1;
            if (beats >= SyncBeatsDefault) begin
              ph = PH_DATA_IN;
              beats = '0;
              rx_bits = '0;
            end
          end
        end
        default: begin
          rx_bits = {rx_bits[LedW-2:0], din};
          beats = beats + 1'b1;
          if (beats >= LedBitsDefault) begin
            led_now = rx_bits;
            r.led_updated = 1'b1;
            ph = PH_IDLE;
            beats = '0;
          end
        end
      endcase
    end
    r.led_level = led_now;
    r.busy_res = (ph != PH_IDLE);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [LedW-1:0] want,
      input logic [LedW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Results are checked before the item of the same edge is predicted, so a
  // result can never be matched against an item that entered with it.
  always @(posedge clk) begin
    cssr_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("result with no item waiting");
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("drive_enable", LedW'(want.drive_enable), LedW'(out_drive_enable));
          check_field("line_level", LedW'(want.line_level), LedW'(out_line_level));
          check_field("led_level", want.led_level, out_led_level);
          check_field("led_updated", LedW'(want.led_updated), LedW'(out_led_updated));
          check_field("busy_res", LedW'(want.busy_res), LedW'(out_busy_res));
        end
      end
      if (in_valid && !in_stall) begin
        want = link_step(in_action, in_data_in, in_x_reading, in_y_reading,
                         in_button_reading);
        if (typed_row) want = typed_want;
        pending_reports.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESH_ONE:   th_one = cfg_data;
          CFG_THRESH_TWO:   th_two = cfg_data;
          CFG_THRESH_THREE: th_three = cfg_data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                  (cfg_valid && cfg_ready)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Result side: random stalls per result, one long hold on request.
  initial begin : reader
    int unsigned wait_cycles;
    int unsigned taken;
    taken = 0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      wait_cycles = reader_eager ? 0 : $urandom_range(0, 9);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 150 == 0) reader_eager = ($urandom_range(0, 2) == 0);
    end
  end

  function automatic stim_row_t readings(input logic din, input logic [ReadingW-1:0] x,
      input logic [ReadingW-1:0] y, input logic [ReadingW-1:0] btn);
    stim_row_t r;
    r = '0;
    r.act = ACT_READINGS;
    r.din = din;
    r.x = x;
    r.y = y;
    r.btn = btn;
    return r;
  endfunction

  function automatic stim_row_t beat(input logic din);
    stim_row_t r;
    r = '0;
    r.act = ACT_BEAT;
    r.din = din;
    r.x = ReadingW'($urandom_range(0, 15));
    r.y = ReadingW'($urandom_range(0, 15));
    r.btn = ReadingW'($urandom_range(0, 15));
    return r;
  endfunction

  function automatic stim_row_t typed(input stim_row_t r, input cssr_result_t want);
    stim_row_t t;
    t = r;
    t.typed = 1'b1;
    t.want = want;
    return t;
  endfunction

  function automatic stim_row_t random_readings();
    return readings(1'($urandom_range(0, 1)), ReadingW'($urandom_range(0, 15)),
                    ReadingW'($urandom_range(0, 15)), ReadingW'($urandom_range(0, 15)));
  endfunction

  task automatic offer(input stim_row_t r);
    int unsigned gap;
    gap = sender_eager ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= r.act;
    in_data_in <= r.din;
    in_x_reading <= r.x;
    in_y_reading <= r.y;
    in_button_reading <= r.btn;
    typed_row <= r.typed;
    typed_want <= r.want;
    do @(posedge clk); while (in_stall);
    items_offered++;
  endtask

  // Readings may slip in between beats at any point of an exchange.
  task automatic offer_beat(input logic din);
    if ($urandom_range(0, 7) == 0) offer(random_readings());
    offer(beat(din));
  endtask

  // Mostly complete exchanges with random content; now and then the
  // handshake back to the block is cut short or garbled.
  task automatic run_exchange();
    logic [LedW-1:0] led_byte;
    int unsigned     led_len;
    repeat ($urandom_range(0, 2)) offer(random_readings());
    repeat (SyncBeatsDefault + SendBits) offer_beat(1'($urandom_range(0, 1)));
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) offer_beat(1'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        repeat ($urandom_range(0, 3)) offer_beat(1'b0);
        offer_beat(1'b1);
      end
      repeat (SyncBeatsDefault) offer_beat(1'b0);
    end
    case ($urandom_range(0, 5))
      0: led_byte = '0;
      1: led_byte = '1;
      default: led_byte = LedW'($urandom_range(0, 255));
    endcase
    led_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, LedBitsDefault - 1)
                                          : LedBitsDefault;
    for (int i = 0; i < led_len; i++) offer_beat(led_byte[LedW-1-i]);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic write_thresholds(input logic [ReadingW-1:0] one,
      input logic [ReadingW-1:0] two, input logic [ReadingW-1:0] three);
    logic [CfgIndexW-1:0] idx[3];
    logic [ReadingW-1:0]  val[3];
    idx = '{CFG_THRESH_ONE, CFG_THRESH_TWO, CFG_THRESH_THREE};
    val = '{one, two, three};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    stim_row_t   directed_rows[NumDirected];
    int unsigned phase_end;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_READINGS;
    in_data_in <= 1'b0;
    in_x_reading <= '0;
    in_y_reading <= '0;
    in_button_reading <= '0;
    typed_row <= 1'b0;
    typed_want <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_THRESH_ONE;
    cfg_data <= '0;

    // One full exchange: the cache is refreshed mid-exchange, a high beat
    // restarts the low-beat count, and the last beat already reports idle.
    directed_rows = '{
      typed(readings(1'b0, 4'hF, 4'h0, 4'h0), '0),
      typed(readings(1'b1, 4'h0, 4'hF, 4'hF), '0),
      typed(beat(1'b1), cssr_result_t'{1'b1, 1'b0, 8'h00, 1'b0, 1'b1}),
      beat(1'b0), beat(1'b1), beat(1'b1),
      readings(1'b0, 4'hF, 4'hF, 4'h6),
      beat(1'b1), beat(1'b0), beat(1'b1), beat(1'b0), beat(1'b1),
      beat(1'b0), beat(1'b1), beat(1'b0), beat(1'b1), beat(1'b0),
      beat(1'b0), beat(1'b1),
      beat(1'b0), beat(1'b0), beat(1'b0), beat(1'b0),
      beat(1'b1), beat(1'b1), beat(1'b1), beat(1'b1),
      beat(1'b1), beat(1'b1), beat(1'b1),
      typed(beat(1'b1), cssr_result_t'{1'b0, 1'b0, 8'hFF, 1'b1, 1'b0})
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) offer(directed_rows[i]);
    in_valid <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      repeat (3) @(posedge clk);
      case (p)
        0: write_thresholds(4'h0, 4'h0, 4'h0);
        1: write_thresholds(4'hF, 4'hF, 4'hF);
        2: write_thresholds(4'hC, 4'h3, 4'h7);
        3: write_thresholds(ReadingW'($urandom_range(0, 15)),
                            ReadingW'($urandom_range(0, 15)),
                            ReadingW'($urandom_range(0, 15)));
        4: write_thresholds(4'h1, 4'h6, 4'hE);
        default: write_thresholds(THRESH_ONE_RST, THRESH_TWO_RST, THRESH_THREE_RST);
      endcase
      sender_eager = (p == 1 || p == 4);
      // The result side holds off for a while so the block fills and
      // pushes back on its input while items keep coming.
      if (p == 2) hold_req = 1'b1;
      phase_end = items_offered + PhaseItems;
      while (items_offered < phase_end) run_exchange();
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cssr_pkg.sv
hw/rtl/cssr_ladder.sv
hw/rtl/cssr_link.sv
hw/rtl/clocked_sync_serial_report_slave_unit.sv
hw/rtl/cssr_checker.sv
dv/tb.sv
